// ----- design/rwx_pkg.sv -----
// Shared types and constants for the run-length window extractor.
// No dependencies; used by rwx_core and rle_window_extract.
`default_nettype none

package rwx_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_RUN_BIAS     = 2'd0;
  localparam logic [1:0] CFG_RAW_SIZE     = 2'd1;
  localparam logic [1:0] CFG_START_POS    = 2'd2;
  localparam logic [1:0] CFG_WINDOW_LEN   = 2'd3;

  localparam int CFG_DATA_W = 31;
  localparam int POS_W      = 31;
  localparam int SIZE_W     = 30;

  localparam logic [6:0]       LOW7_MASK = 7'h7f;
  localparam logic [POS_W-1:0] POS_MAX   = 31'h7fffffff;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_RUN  = 2'd1,
    PH_LIT  = 2'd2
  } phase_t;

  // One compressed byte with its framing marks
  typedef struct packed {
    logic [7:0] coded_byte;
    logic       first_byte;
    logic       final_byte;
  } rwx_in_t;

  // One decoded group inside the window
  typedef struct packed {
    logic [7:0] char_value;
    logic [7:0] repeat_count;
    logic       window_done;
    logic       short_stream;
  } rwx_out_t;

  // Window settings, kept partly pre-added at configuration time
  typedef struct packed {
    logic signed [31:0] start_off;  // start_position - 1
    logic signed [32:0] end_sum;    // start_position - 1 + window_length
    logic [SIZE_W-1:0]  raw_size;
    logic [7:0]         run_bias;
  } rwx_cfg_t;

endpackage

`default_nettype wire

// ----- design/rwx_core.sv -----
// Decoder state and the per-byte step: parse, position tracking, window cut.
// Depends on rwx_pkg.
`default_nettype none

module rwx_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire rwx_pkg::rwx_in_t   item,
  input  wire rwx_pkg::rwx_cfg_t  cfg,
  output logic                    res_valid,
  output rwx_pkg::rwx_out_t       res
);

  rwx_pkg::phase_t              phase, phase_next, phase_c;
  logic [7:0]                   group_rem, group_rem_next, group_c;
  logic [7:0]                   run_held, run_held_next, held_c;
  logic [rwx_pkg::POS_W-1:0]    raw_pos, raw_pos_next, pos_c;
  logic [rwx_pkg::SIZE_W-1:0]   win_start, win_start_next;
  logic [rwx_pkg::SIZE_W-1:0]   win_end, win_end_next;
  logic                         finished, finished_next, fin_c;

  logic [rwx_pkg::SIZE_W-1:0]   ws_new, we_new, start_nonneg;
  logic signed [32:0]           end_max;
  logic                         empty_win;

  logic [7:0]                   span_cnt;
  logic [31:0]                  pos_end;
  logic [rwx_pkg::POS_W-1:0]    lo;
  logic [31:0]                  hi;
  logic [31:0]                  span_full;
  logic                         in_win, span_done;
  logic [rwx_pkg::POS_W-1:0]    pos_sat;
  logic [8:0]                   run_sum;
  logic [6:0]                   low7;

  // Window from configuration: start = clip(max(off,0)), end = clip(max(off+len, start))
  always_comb begin
    start_nonneg = cfg.start_off[31] ? '0 : cfg.start_off[rwx_pkg::SIZE_W-1:0];
    ws_new = (start_nonneg > cfg.raw_size) ? cfg.raw_size : start_nonneg;
    end_max = (cfg.end_sum > $signed({3'b000, start_nonneg})) ?
              cfg.end_sum : $signed({3'b000, start_nonneg});
    we_new = (end_max > $signed({3'b000, cfg.raw_size})) ?
             cfg.raw_size : end_max[rwx_pkg::SIZE_W-1:0];
  end

  // A first byte restarts the decoder before the byte is looked at
  always_comb begin
    phase_c = item.first_byte ? rwx_pkg::PH_CTRL : phase;
    group_c = item.first_byte ? 8'd0 : group_rem;
    held_c  = item.first_byte ? 8'd0 : run_held;
    pos_c   = item.first_byte ? '0 : raw_pos;
    fin_c   = item.first_byte ? 1'b0 : finished;
    empty_win = item.first_byte && (ws_new == we_new);
  end

  // Span of the current run or literal against the window
  always_comb begin
    span_cnt  = (phase_c == rwx_pkg::PH_RUN) ? held_c : 8'd1;
    pos_end   = {1'b0, pos_c} + {24'd0, span_cnt};
    lo        = (pos_c > {1'b0, win_start}) ? pos_c : {1'b0, win_start};
    hi        = (pos_end < {2'b00, win_end}) ? pos_end : {2'b00, win_end};
    in_win    = hi > {1'b0, lo};
    span_full = hi - {1'b0, lo};
    span_done = pos_end >= {2'b00, win_end};
    pos_sat   = pos_end[31] ? rwx_pkg::POS_MAX : pos_end[rwx_pkg::POS_W-1:0];
    low7      = item.coded_byte[6:0] & rwx_pkg::LOW7_MASK;
    run_sum   = {2'b00, low7} + {1'b0, cfg.run_bias};
  end

  // Next state and result of one byte
  always_comb begin
    phase_next     = phase_c;
    group_rem_next = group_c;
    run_held_next  = held_c;
    raw_pos_next   = pos_c;
    finished_next  = fin_c;
    win_start_next = item.first_byte ? ws_new : win_start;
    win_end_next   = item.first_byte ? we_new : win_end;
    res_valid      = 1'b0;
    res            = '0;

    if (empty_win) begin
      res_valid       = 1'b1;
      res.window_done = 1'b1;
      finished_next   = 1'b1;
    end else if (!fin_c) begin
      case (phase_c)
        rwx_pkg::PH_RUN, rwx_pkg::PH_LIT: begin
          if (in_win) begin
            res_valid        = 1'b1;
            res.char_value   = item.coded_byte;
            res.repeat_count = span_full[7:0];
            res.window_done  = span_done;
            if (span_done) begin
              finished_next = 1'b1;
            end
          end
          raw_pos_next = pos_sat;
          if (phase_c == rwx_pkg::PH_RUN) begin
            phase_next = rwx_pkg::PH_CTRL;
          end else begin
            group_rem_next = group_c - 8'd1;
            if (group_c == 8'd1) begin
              phase_next = rwx_pkg::PH_CTRL;
            end
          end
        end
        default: begin
          // control byte
          if (item.coded_byte[7]) begin
            run_held_next = run_sum[8] ? 8'hff : run_sum[7:0];
            phase_next    = rwx_pkg::PH_RUN;
          end else if (low7 != 7'd0) begin
            group_rem_next = {1'b0, low7};
            phase_next     = rwx_pkg::PH_LIT;
          end else begin
            phase_next = rwx_pkg::PH_CTRL;
          end
        end
      endcase

      // body ended before the window closed; a restart byte uses its new window
      if (item.final_byte && !finished_next) begin
        if (res_valid) begin
          res.window_done  = 1'b1;
          res.short_stream = 1'b1;
        end else begin
          res_valid        = 1'b1;
          res.window_done  = 1'b1;
          res.short_stream = {1'b0, win_end_next} > raw_pos_next;
        end
        finished_next = 1'b1;
      end
    end
  end

  // State registers advance once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rwx_pkg::PH_CTRL;
      group_rem <= '0;
      run_held  <= '0;
      raw_pos   <= '0;
      win_start <= '0;
      win_end   <= '0;
      finished  <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      group_rem <= group_rem_next;
      run_held  <= run_held_next;
      raw_pos   <= raw_pos_next;
      win_start <= win_start_next;
      win_end   <= win_end_next;
      finished  <= finished_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/rle_window_extract.sv -----
// Top level of the run-length window extractor: configuration registers,
// input register, decoder core and output register. Depends on rwx_pkg, rwx_core.
`default_nettype none

// Decodes a run-length coded body one byte per transfer and returns, for each
// run or literal byte, the part that falls inside the window set by
// start_position and window_length (clipped to raw_size). A byte with
// first_byte set restarts decoding and loads the window; an empty window is
// answered at once with window_done. A byte passes from input to output
// through the input register, then the decode step into the output register,
// and a new byte is accepted every cycle while the output is not stalled; the
// decode step, which updates position and window state, sets that rate. Bytes
// that cause no result produce no output transfer. Configuration writes take
// effect for the next decoded byte; window settings load with first_byte.

module rle_window_extract (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire rwx_pkg::rwx_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output rwx_pkg::rwx_out_t                     out_data,
  input  wire logic                             cfg_write,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [rwx_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rwx_pkg::rwx_cfg_t   cfg;
  logic signed [30:0]  window_length;
  logic signed [31:0]  wdata_off;

  logic                s1_valid;
  rwx_pkg::rwx_in_t    s1_item;
  logic                adv, fire;
  logic                res_valid;
  rwx_pkg::rwx_out_t   res;

  assign wdata_off = $signed({cfg_data[30], cfg_data}) - 32'sd1;

  // Configuration registers; start offset and end sum are pre-added here
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_bias  <= 8'd3;
      cfg.raw_size  <= '0;
      cfg.start_off <= '0;
      cfg.end_sum   <= '0;
      window_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rwx_pkg::CFG_RUN_BIAS: cfg.run_bias <= cfg_data[7:0];
        rwx_pkg::CFG_RAW_SIZE: cfg.raw_size <= cfg_data[rwx_pkg::SIZE_W-1:0];
        rwx_pkg::CFG_START_POS: begin
          cfg.start_off <= wdata_off;
          cfg.end_sum   <= $signed({wdata_off[31], wdata_off}) +
                           $signed({{2{window_length[30]}}, window_length});
        end
        rwx_pkg::CFG_WINDOW_LEN: begin
          window_length <= $signed(cfg_data);
          cfg.end_sum   <= $signed({cfg.start_off[31], cfg.start_off}) +
                           $signed({{2{cfg_data[30]}}, cfg_data});
        end
        default: ;
      endcase
    end
  end

  // Input register; the decode step fires when the output register has room
  assign adv      = !out_valid || !out_stall;
  assign fire     = s1_valid && adv;
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  rwx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .item      (s1_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data <= res;
    end
  end

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_item))
    else $error("pending byte lost from input register");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |-> (res.repeat_count != 8'd0) || res.window_done)
    else $error("empty group emitted inside the window");

  a_short_is_done: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.short_stream |=> out_valid && out_data.window_done)
    else $error("short stream flag without window end");

endmodule

`default_nettype wire

// ----- verif/rle_window_extract_test.sv -----
// Self-checking testbench for rle_window_extract: directed and random coded streams.
// It carries its own decoder and window model. Depends on rwx_pkg and the design.

module rle_window_extract_test;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 4;     // pipeline depth plus margin

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  rwx_pkg::rwx_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rwx_pkg::rwx_out_t              out_data;
  logic                           cfg_write;
  logic [1:0]                     cfg_index;
  logic [rwx_pkg::CFG_DATA_W-1:0] cfg_data;

  // Groups the window should still produce, oldest first
  rwx_pkg::rwx_out_t groups_due[$];
  rwx_pkg::rwx_out_t want;

  // Register copies
  logic [7:0]                 bias_r  = 8'd3;
  logic [rwx_pkg::SIZE_W-1:0] size_r  = '0;
  logic [30:0]                start_r = 31'd1;
  logic [30:0]                len_r   = '0;

  // Decoder state
  rwx_pkg::phase_t            cur_phase  = rwx_pkg::PH_CTRL;
  logic [7:0]                 lit_left   = '0;
  logic [7:0]                 run_len    = '0;
  logic [rwx_pkg::POS_W-1:0]  dec_pos    = '0;
  logic [rwx_pkg::SIZE_W-1:0] win_lo     = '0;
  logic [rwx_pkg::POS_W-1:0]  win_hi     = '0;
  bit                         win_closed = 1'b0;

  int errors         = 0;
  int bytes_sent     = 0;
  int groups_checked = 0;
  int streams_played = 0;
  int quiet_cycles   = 0;
  int stall_left     = 0;
  bit idle_on        = 1'b1;

  rle_window_extract u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Part of cnt copies at the current position that falls in the window
  task automatic take_span(input logic [7:0] value, input logic [7:0] cnt,
                           output bit hit, output rwx_pkg::rwx_out_t g);
    longint pos, top, lo, hi, span;
    pos = dec_pos;
    top = pos + cnt;
    lo = (pos > win_lo) ? pos : win_lo;
    hi = (top < win_hi) ? top : win_hi;
    hit = 1'b0;
    g = '0;
    if (hi > lo) begin
      span = hi - lo;
      g.char_value   = value;
      g.repeat_count = span[7:0];
      g.window_done  = (top >= win_hi);
      if (g.window_done) win_closed = 1'b1;
      hit = 1'b1;
    end
    dec_pos = (top > rwx_pkg::POS_MAX) ? rwx_pkg::POS_MAX : top[rwx_pkg::POS_W-1:0];
  endtask

  // Decode one accepted byte and queue the group it yields, if any
  task automatic decode_step(input rwx_pkg::rwx_in_t it);
    rwx_pkg::rwx_out_t g;
    bit                hit;
    longint            s_off, s_len, raw, e_pos;
    int                low7, c;
    hit = 1'b0;
    g = '0;
    if (it.first_byte) begin
      cur_phase  = rwx_pkg::PH_CTRL;
      lit_left   = '0;
      run_len    = '0;
      dec_pos    = '0;
      win_closed = 1'b0;
      s_off = $signed(start_r);
      s_off = s_off - 1;
      s_len = $signed(len_r);
      raw   = size_r;
      if (s_off < 0) begin
        s_len = s_len + s_off;
        s_off = 0;
      end
      if (s_len < 0) s_len = 0;
      if (s_off > raw) s_off = raw;
      if (s_off + s_len > raw) s_len = raw - s_off;
      e_pos  = s_off + s_len;
      win_lo = s_off[rwx_pkg::SIZE_W-1:0];
      win_hi = e_pos[rwx_pkg::POS_W-1:0];
      // empty window: answered at once, byte dropped
      if (win_lo == win_hi) begin
        g.window_done = 1'b1;
        win_closed = 1'b1;
        groups_due.push_back(g);
        return;
      end
    end
    if (win_closed) return;

    case (cur_phase)
      rwx_pkg::PH_RUN: begin
        take_span(it.coded_byte, run_len, hit, g);
        cur_phase = rwx_pkg::PH_CTRL;
      end
      rwx_pkg::PH_LIT: begin
        take_span(it.coded_byte, 8'd1, hit, g);
        lit_left = lit_left - 8'd1;
        if (lit_left == 0) cur_phase = rwx_pkg::PH_CTRL;
      end
      default: begin
        low7 = it.coded_byte[6:0];
        if (it.coded_byte[7]) begin
          c = low7 + bias_r;
          run_len = (c > 255) ? 8'd255 : c[7:0];
          cur_phase = rwx_pkg::PH_RUN;
        end else if (low7 != 0) begin
          lit_left = low7[7:0];
          cur_phase = rwx_pkg::PH_LIT;
        end else begin
          cur_phase = rwx_pkg::PH_CTRL;
        end
      end
    endcase

    // body ended before the window closed
    if (it.final_byte && !win_closed) begin
      if (hit) begin
        g.window_done  = 1'b1;
        g.short_stream = 1'b1;
      end else begin
        g = '0;
        g.window_done  = 1'b1;
        g.short_stream = (win_hi > dec_pos);
        hit = 1'b1;
      end
      win_closed = 1'b1;
    end
    if (hit) groups_due.push_back(g);
  endtask

  // One input transfer, with an optional gap ahead of it
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    rwx_pkg::rwx_in_t it;
    int               gap;
    it.coded_byte = b;
    it.first_byte = first;
    it.final_byte = last;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(it);
    bytes_sent++;
  endtask

  // Stop sending and let every pending result come out
  task automatic drain();
    in_valid <= 1'b0;
    while (groups_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      rwx_pkg::CFG_RUN_BIAS:   bias_r  = val[7:0];
      rwx_pkg::CFG_RAW_SIZE:   size_r  = val[rwx_pkg::SIZE_W-1:0];
      rwx_pkg::CFG_START_POS:  start_r = val;
      rwx_pkg::CFG_WINDOW_LEN: len_r   = val;
      default: ;
    endcase
  endtask

  // Caller makes sure the block is idle
  task automatic configure(input logic [7:0] bias, input logic [rwx_pkg::SIZE_W-1:0] size,
                           input logic [30:0] start, input logic [30:0] len);
    put_reg(rwx_pkg::CFG_RUN_BIAS, {23'd0, bias});
    put_reg(rwx_pkg::CFG_RAW_SIZE, {1'b0, size});
    put_reg(rwx_pkg::CFG_START_POS, start);
    put_reg(rwx_pkg::CFG_WINDOW_LEN, len);
    cfg_write <= 1'b0;
  endtask

  // Signed window value: mostly near the data, sometimes at the extremes
  function automatic logic [30:0] pick_signed(input int span);
    int t;
    case ($urandom_range(0, 9))
      0: return 31'h40000000;
      1: return 31'h3fffffff;
      2: return 31'($urandom());
      3: begin
        t = $urandom_range(0, 2) - 1;
        return t[30:0];
      end
      default: begin
        t = $urandom_range(0, span + 10) - 5;
        return t[30:0];
      end
    endcase
  endfunction

  task automatic random_config();
    logic [7:0]                 b;
    logic [rwx_pkg::SIZE_W-1:0] sz;
    int                         span;
    case ($urandom_range(0, 3))
      0: b = 8'd1;
      1: b = 8'd128;
      default: b = 8'($urandom_range(1, 128));
    endcase
    case ($urandom_range(0, 9))
      0: sz = '0;
      1: sz = '1;
      2: sz = 30'($urandom());
      default: sz = 30'($urandom_range(0, 400));
    endcase
    span = (sz > 400) ? 400 : sz;
    configure(b, sz, pick_signed(span), pick_signed(span));
  endtask

  // One coded body: well formed, truncated, left open, restarted midway, or noise
  task automatic play_stream(input int kind);
    logic [7:0] body[$];
    int         target, made, low, n, cut, restart;
    bit         close;
    streams_played++;
    if (kind == 2) begin
      n = $urandom_range(1, 10);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                           $urandom_range(0, 5) == 0);
      return;
    end
    target = (size_r <= 400) ? int'(size_r) + $urandom_range(0, 40) - 20
                             : $urandom_range(0, 300);
    made = 0;
    while (made < target) begin
      n = $urandom_range(0, 9);
      if (n < 5) begin
        low = $urandom_range(0, 127);
        body.push_back({1'b1, low[6:0]});
        body.push_back(8'($urandom_range(0, 255)));
        made += (low + bias_r > 255) ? 255 : low + bias_r;
      end else if (n < 9) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
        body.push_back(n[7:0]);
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
        made += n;
      end else begin
        body.push_back(8'h00);
      end
    end
    if (body.size() == 0) body.push_back(8'h00);
    close = 1'b1;
    restart = -1;
    if (kind == 0 && body.size() > 1) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end
    if (kind == 1) close = 1'b0;
    if (kind == 3) restart = $urandom_range(0, body.size() - 1);
    for (int i = 0; i < body.size(); i++)
      send_byte(body[i], i == 0 || i == restart, close && i == body.size() - 1);
  endtask

  // Bytes with no restart after reset use the empty reset window
  task automatic test_reset_window();
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_empty_window();
    drain();
    configure(8'd3, 30'd10, 31'd1, 31'd0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h83, 1'b0, 1'b0);
  endtask

  // Run, zero literal count, three literals, long run closing the window
  task automatic test_runs_and_literals();
    drain();
    configure(8'd3, 30'd20, 31'd3, 31'd8);
    send_byte(8'h82, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b1);
  endtask

  // Early end with and without a group, largest sizes, most negative start
  task automatic test_window_edges();
    drain();
    configure(8'd3, 30'd20, 31'd1, 31'd20);
    send_byte(8'h83, 1'b1, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    drain();
    configure(8'd3, 30'h3fffffff, 31'h3fffffff, 31'h3fffffff);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h12, 1'b0, 1'b1);
    drain();
    configure(8'd3, 30'h3fffffff, 31'h40000000, 31'h3fffffff);
    send_byte(8'h7F, 1'b1, 1'b0);
  endtask

  // Largest bias in range, then one that saturates the run length
  task automatic test_run_bias();
    drain();
    configure(8'd128, 30'd300, 31'd1, 31'd300);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    drain();
    configure(8'd200, 30'd400, 31'd1, 31'd400);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_streams();
    int base;
    base = bytes_sent;
    drain();
    random_config();
    while (bytes_sent - base < 800) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        random_config();
      end
      idle_on = ($urandom_range(0, 3) != 0);
      play_stream($urandom_range(0, 9));
    end
  endtask

  // Closing part: full rate on both sides
  task automatic test_back_to_back();
    drain();
    idle_on = 1'b0;
    configure(8'd3, 30'd200, 31'd10, 31'd150);
    repeat (6) play_stream(9);
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each output transfer with the oldest pending group
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (groups_due.size() == 0) begin
        $error("unexpected group: char_value %0d repeat_count %0d",
               out_data.char_value, out_data.repeat_count);
        errors = errors + 1;
      end else begin
        want = groups_due.pop_front();
        groups_checked++;
        if (out_data.char_value !== want.char_value) begin
          $error("char_value: expected %0d, got %0d", want.char_value, out_data.char_value);
          errors = errors + 1;
        end
        if (out_data.repeat_count !== want.repeat_count) begin
          $error("repeat_count: expected %0d, got %0d",
                 want.repeat_count, out_data.repeat_count);
          errors = errors + 1;
        end
        if (out_data.window_done !== want.window_done) begin
          $error("window_done: expected %0b, got %0b", want.window_done, out_data.window_done);
          errors = errors + 1;
        end
        if (out_data.short_stream !== want.short_stream) begin
          $error("short_stream: expected %0b, got %0b",
                 want.short_stream, out_data.short_stream);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d groups pending",
               quiet_cycles, groups_due.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = rwx_pkg::CFG_RUN_BIAS;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_empty_window();
    test_runs_and_literals();
    test_window_edges();
    test_run_bias();
    test_random_streams();
    test_back_to_back();

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d coded bytes in %0d streams, %0d decoded groups checked,",
             bytes_sent, streams_played, groups_checked);
    $display("over directed window edges and random window settings; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rwx_pkg.sv
design/rwx_core.sv
design/rle_window_extract.sv
verif/rle_window_extract_test.sv
